// ----- sv/rocca_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rocca_pkg;

  localparam int unsigned ROUNDS   = 20;
  localparam int unsigned CNT_W    = $clog2(ROUNDS);
  localparam int unsigned BLK      = 32;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned CNT_FLD_W = 6;
  localparam int unsigned PADDR_W  = 6;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_AD   = 2'd1,
    CMD_MSG  = 2'd2,
    CMD_FIN  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE0 = 3'd4,
    REG_NONCE1 = 3'd5,
    REG_MODE  = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_FIN,
    ST_TAG
  } ctrl_state_e;

  typedef logic [7:0][127:0] state_t;

  typedef struct packed {
    logic [DATA_W-1:0] key0;
    logic [DATA_W-1:0] key1;
    logic [DATA_W-1:0] key2;
    logic [DATA_W-1:0] key3;
    logic [DATA_W-1:0] nonce0;
    logic [DATA_W-1:0] nonce1;
    logic              decrypt;
  } cfg_t;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    logic load_init;
    logic run_round;
    logic use_len;
    logic ad_blk;
    logic msg_blk;
    logic fin_start;
    logic tag_out;
  } dp_cmd_t;

  localparam logic [127:0] Z0 = 128'h428a2f98_d728ae22_71374491_23ef65cd;
  localparam logic [127:0] Z1 = 128'hb5c0fbcf_ec4d3b2f_e9b5dba5_8189dbbc;

  // Entry 0 sits in the top byte.
  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(logic [7:0] x);
    logic [10:0] off;
    off = {~x, 3'b000};
    return SBOX_TBL[off +: 8];
  endfunction

  function automatic logic [7:0] xt(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One keyless AES round (SubBytes, ShiftRows, MixColumns) followed by XOR with k.
  function automatic logic [127:0] aes_enc_rk(logic [127:0] x, logic [127:0] k);
    logic [7:0]   t [16];
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = sbox(x[8*(4*((c+r)%4)+r) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      o[8*(4*c)   +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3 ^ k[8*(4*c)   +: 8];
      o[8*(4*c+1) +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3 ^ k[8*(4*c+1) +: 8];
      o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3 ^ k[8*(4*c+2) +: 8];
      o[8*(4*c+3) +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3) ^ k[8*(4*c+3) +: 8];
    end
    return o;
  endfunction

  function automatic state_t rocca_round(state_t s, logic [127:0] x0, logic [127:0] x1);
    state_t n;
    n[0] = s[7] ^ x0;
    n[1] = aes_enc_rk(s[0], s[7]);
    n[2] = s[1] ^ s[6];
    n[3] = aes_enc_rk(s[2], s[1]);
    n[4] = s[3] ^ x1;
    n[5] = aes_enc_rk(s[4], s[3]);
    n[6] = aes_enc_rk(s[5], s[4]);
    n[7] = s[0] ^ s[6];
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rocca_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rocca_in_if;
  logic                             valid;
  logic                             ready;
  rocca_pkg::cmd_e                  cmd;
  logic [rocca_pkg::DATA_W-1:0]     data_w0;
  logic [rocca_pkg::DATA_W-1:0]     data_w1;
  logic [rocca_pkg::DATA_W-1:0]     data_w2;
  logic [rocca_pkg::DATA_W-1:0]     data_w3;
  logic [rocca_pkg::CNT_FLD_W-1:0]  byte_count;

  modport source (output valid, cmd, data_w0, data_w1, data_w2, data_w3, byte_count,
                  input ready);
  modport sink (input valid, cmd, data_w0, data_w1, data_w2, data_w3, byte_count,
                output ready);
endinterface

interface rocca_out_if;
  logic                         valid;
  logic                         ready;
  logic [rocca_pkg::DATA_W-1:0] out_w0;
  logic [rocca_pkg::DATA_W-1:0] out_w1;
  logic [rocca_pkg::DATA_W-1:0] out_w2;
  logic [rocca_pkg::DATA_W-1:0] out_w3;
  logic                         tag_match;

  modport source (output valid, out_w0, out_w1, out_w2, out_w3, tag_match, input ready);
  modport sink (input valid, out_w0, out_w1, out_w2, out_w3, tag_match, output ready);
endinterface

`default_nettype wire

// ----- sv/rocca_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rocca_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  rocca_pkg::cmd_e         in_cmd_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rocca_pkg::dp_cmd_t      dp_cmd_o
);
  import rocca_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             last;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign last        = (cnt_q == CNT_W'(ROUNDS - 1));
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_cmd_i == CMD_INIT) begin
          state_d = ST_INIT;
        end else if (accept && in_cmd_i == CMD_FIN) begin
          state_d = ST_FIN;
        end
      end
      ST_INIT: if (last) state_d = ST_IDLE;
      ST_FIN:  if (last) state_d = ST_TAG;
      ST_TAG:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o = '0;
    cnt_d    = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          case (in_cmd_i)
            CMD_INIT: dp_cmd_o.load_init = 1'b1;
            CMD_AD:   dp_cmd_o.ad_blk    = 1'b1;
            CMD_MSG:  dp_cmd_o.msg_blk   = 1'b1;
            CMD_FIN:  dp_cmd_o.fin_start = 1'b1;
            default:  dp_cmd_o.ad_blk    = 1'b0;
          endcase
        end
      end
      ST_INIT: begin
        dp_cmd_o.run_round = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end
      ST_FIN: begin
        dp_cmd_o.run_round = 1'b1;
        dp_cmd_o.use_len   = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end
      ST_TAG: dp_cmd_o.tag_out = 1'b1;
      default: cnt_d = '0;
    endcase
  end

  always_comb begin
    if (dp_cmd_o.msg_blk || dp_cmd_o.tag_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rocca_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rocca_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  rocca_pkg::cfg_t                       cfg_i,
  input  rocca_pkg::dp_cmd_t                    cmd_i,
  input  wire logic [4*rocca_pkg::DATA_W-1:0]   data_i,
  input  wire logic [rocca_pkg::CNT_FLD_W-1:0]  byte_count_i,
  output logic [4*rocca_pkg::DATA_W-1:0]        out_data_o,
  output logic                                  tag_match_o
);
  import rocca_pkg::*;

  state_t                 s_q, s_d;
  logic [DATA_W-1:0]      ad_tot_q, ad_tot_d;
  logic [DATA_W-1:0]      msg_tot_q, msg_tot_d;
  logic [127:0]           exp_q;
  logic [4*DATA_W-1:0]    out_q;
  logic                   match_q;

  logic [CNT_FLD_W-1:0]   n;
  logic [8*BLK-1:0]       keep;
  logic [8*BLK-1:0]       dpad, ks, o, p, x;
  logic [127:0]           x0, x1, tag;
  state_t                 init_s;

  // Counts above a full block saturate.
  assign n = (byte_count_i > CNT_FLD_W'(BLK)) ? CNT_FLD_W'(BLK) : byte_count_i;

  always_comb begin
    for (int i = 0; i < BLK; i++) begin
      keep[8*i +: 8] = (CNT_FLD_W'(i) < n) ? 8'hff : 8'h00;
    end
  end

  assign dpad = data_i & keep;
  assign ks   = {aes_enc_rk(s_q[0] ^ s_q[4], s_q[2]), aes_enc_rk(s_q[1], s_q[5])};
  assign o    = (data_i ^ ks) & keep;
  assign p    = cfg_i.decrypt ? o : dpad;
  assign x    = cmd_i.msg_blk ? p : dpad;

  always_comb begin
    if (cmd_i.run_round && cmd_i.use_len) begin
      x0 = {64'd0, ad_tot_q << 3};
      x1 = {64'd0, msg_tot_q << 3};
    end else if (cmd_i.run_round) begin
      x0 = Z0;
      x1 = Z1;
    end else begin
      x0 = x[127:0];
      x1 = x[255:128];
    end
  end

  always_comb begin
    init_s[0] = {cfg_i.key3, cfg_i.key2};
    init_s[1] = {cfg_i.nonce1, cfg_i.nonce0};
    init_s[2] = Z0;
    init_s[3] = Z1;
    init_s[4] = init_s[0] ^ init_s[1];
    init_s[5] = '0;
    init_s[6] = {cfg_i.key1, cfg_i.key0};
    init_s[7] = '0;
  end

  always_comb begin
    tag = s_q[0];
    for (int i = 1; i < 8; i++) begin
      tag = tag ^ s_q[i];
    end
  end

  always_comb begin
    s_d       = s_q;
    ad_tot_d  = ad_tot_q;
    msg_tot_d = msg_tot_q;
    if (cmd_i.load_init) begin
      s_d       = init_s;
      ad_tot_d  = '0;
      msg_tot_d = '0;
    end else if (cmd_i.run_round || cmd_i.ad_blk || cmd_i.msg_blk) begin
      s_d = rocca_round(s_q, x0, x1);
    end
    if (cmd_i.ad_blk) ad_tot_d = ad_tot_q + DATA_W'(n);
    if (cmd_i.msg_blk) msg_tot_d = msg_tot_q + DATA_W'(n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q       <= '0;
      ad_tot_q  <= '0;
      msg_tot_q <= '0;
    end else begin
      s_q       <= s_d;
      ad_tot_q  <= ad_tot_d;
      msg_tot_q <= msg_tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_start) begin
      exp_q <= data_i[127:0];
    end
    if (cmd_i.msg_blk) begin
      out_q   <= o;
      match_q <= 1'b0;
    end else if (cmd_i.tag_out) begin
      out_q   <= {128'd0, tag};
      match_q <= cfg_i.decrypt && (tag == exp_q);
    end
  end

  assign out_data_o  = out_q;
  assign tag_match_o = match_q;

endmodule

`default_nettype wire

// ----- sv/rocca_aead_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Rocca authenticated cipher core with a 256-bit key and a 128-bit nonce.
// Key, nonce and the decrypt mode bit are written through the APB port
// (64-bit registers at byte addresses 0, 8, ..., 48); the user must do so
// only while the core is idle, which the block does not enforce. Commands
// arrive as beats on in_if: init, associated-data block, message block or
// finalize, with up to 32 data bytes and a byte count. A message beat
// advances the state as it is accepted, and its ciphertext or plaintext beat
// is on out_if in the next cycle; an associated-data beat advances the state
// too but gives no beat. Init and finalize each run 20 state updates, one per
// cycle, through the single round unit of four parallel AES rounds, taking no
// beat meanwhile; finalize then gives its tag beat through ST_TAG. The output
// register holds a beat until out_if.ready is high; a new beat is accepted
// while a result waits only in the cycle in which it is taken. Reset clears
// the cipher state, the byte totals and all configuration.
module rocca_aead_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rocca_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rocca_pkg::DATA_W-1:0] pwdata,
  output logic [rocca_pkg::DATA_W-1:0]      prdata,
  output logic                              pready,
  rocca_in_if.sink                          in_if,
  rocca_out_if.source                       out_if
);
  import rocca_pkg::*;

  cfg_t                cfg_q;
  dp_cmd_t             dp_cmd;
  logic                wr_en;
  reg_idx_e            reg_idx;
  logic [4*DATA_W-1:0] out_data;

  // Registers sit on 8-byte boundaries.
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY0:   cfg_q.key0    <= pwdata;
        REG_KEY1:   cfg_q.key1    <= pwdata;
        REG_KEY2:   cfg_q.key2    <= pwdata;
        REG_KEY3:   cfg_q.key3    <= pwdata;
        REG_NONCE0: cfg_q.nonce0  <= pwdata;
        REG_NONCE1: cfg_q.nonce1  <= pwdata;
        REG_MODE:   cfg_q.decrypt <= pwdata[0];
        default:    cfg_q         <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY0:   prdata = cfg_q.key0;
      REG_KEY1:   prdata = cfg_q.key1;
      REG_KEY2:   prdata = cfg_q.key2;
      REG_KEY3:   prdata = cfg_q.key3;
      REG_NONCE0: prdata = cfg_q.nonce0;
      REG_NONCE1: prdata = cfg_q.nonce1;
      REG_MODE:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.decrypt};
      default:    prdata = '0;
    endcase
  end

  rocca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_cmd_i    (in_if.cmd),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .dp_cmd_o    (dp_cmd)
  );

  rocca_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (dp_cmd),
    .data_i       ({in_if.data_w3, in_if.data_w2, in_if.data_w1, in_if.data_w0}),
    .byte_count_i (in_if.byte_count),
    .out_data_o   (out_data),
    .tag_match_o  (out_if.tag_match)
  );

  assign out_if.out_w0 = out_data[DATA_W-1:0];
  assign out_if.out_w1 = out_data[2*DATA_W-1:DATA_W];
  assign out_if.out_w2 = out_data[3*DATA_W-1:2*DATA_W];
  assign out_if.out_w3 = out_data[4*DATA_W-1:3*DATA_W];

`ifndef ASSERT_OFF
  // A new beat is only taken when the output register is free by then.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> (!out_if.valid || out_if.ready))
    else $error("input accepted while a result is stalled");

  // Init keeps the core busy for its rounds.
  a_init_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.cmd == CMD_INIT) |=> !in_if.ready)
    else $error("core ready right after init");

  // A tag match can only be reported in decrypt mode.
  a_match_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.tag_match) |-> cfg_q.decrypt)
    else $error("tag match outside decrypt mode");
`endif

endmodule

`default_nettype wire

// ----- tb/rocca_tb_if.sv -----
`timescale 1ns / 1ps

// The channel interfaces live with the RTL; this file only holds the
// register address map that testbench.sv uses.
package rocca_tb_pkg;
  import rocca_pkg::*;

  // 64-bit registers, so register i sits at byte address 8*i.
  function automatic logic [PADDR_W-1:0] reg_addr(reg_idx_e idx);
    return PADDR_W'(8 * int'(idx));
  endfunction
endpackage

// ----- tb/rocca_checker.sv -----
`timescale 1ns / 1ps

module rocca_checker
  import rocca_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]      pwdata,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  cmd_e                   in_cmd,
  input  logic [4*DATA_W-1:0]    in_data,
  input  logic [CNT_FLD_W-1:0]   in_count,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [4*DATA_W-1:0]    out_data,
  input  logic                   out_match,
  output int                     fail_count,
  output int                     pending_o
);

  typedef struct packed {
    logic [4*DATA_W-1:0] data;
    logic                match;
  } beat_t;

  localparam logic [127:0] ZC0 = 128'h428a2f98_d728ae22_71374491_23ef65cd;
  localparam logic [127:0] ZC1 = 128'hb5c0fbcf_ec4d3b2f_e9b5dba5_8189dbbc;

  beat_t          expected_beats[$];
  logic [255:0]   key_q;
  logic [127:0]   nonce_q;
  logic           decrypt_q;
  logic [127:0]   st [8];
  logic [63:0]    ad_total, msg_total;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b >>= 1;
    end
    return r;
  endfunction

  // S-box computed from the field inverse and the affine map.
  function automatic logic [7:0] sub_byte(logic [7:0] x);
    logic [7:0] p, r, s;
    p = x;
    r = 8'h01;
    for (int i = 1; i < 8; i++) begin
      p = gmul(p, p);
      r = gmul(r, p);
    end
    s = r;
    for (int i = 1; i < 5; i++) s ^= (r << i) | (r >> (8 - i));
    return s ^ 8'h63;
  endfunction

  function automatic logic [7:0] dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_mix(logic [127:0] x, logic [127:0] k);
    logic [7:0]   t [16];
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = sub_byte(x[8*(4*((c+r)%4)+r) +: 8]);
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      o[8*(4*c)   +: 8] = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
      o[8*(4*c+1) +: 8] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
      o[8*(4*c+2) +: 8] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
      o[8*(4*c+3) +: 8] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
    end
    return o ^ k;
  endfunction

  task automatic advance(input logic [127:0] x0, input logic [127:0] x1);
    logic [127:0] n [8];
    n[0] = st[7] ^ x0;
    n[1] = aes_mix(st[0], st[7]);
    n[2] = st[1] ^ st[6];
    n[3] = aes_mix(st[2], st[1]);
    n[4] = st[3] ^ x1;
    n[5] = aes_mix(st[4], st[3]);
    n[6] = aes_mix(st[5], st[4]);
    n[7] = st[0] ^ st[6];
    st = n;
  endtask

  task automatic predict_beat(input cmd_e cmd, input logic [255:0] din,
                              input logic [5:0] cnt_raw);
    int           n;
    logic [255:0] blk, ks, ct, fed, mask;
    logic [127:0] tag;
    beat_t        b;
    n = (cnt_raw > 32) ? 32 : int'(cnt_raw);
    mask = (n == 32) ? '1 : ((256'd1 << (8 * n)) - 1);
    blk = din & mask;
    case (cmd)
      CMD_INIT: begin
        st[0] = key_q[255:128];
        st[1] = nonce_q;
        st[2] = ZC0;
        st[3] = ZC1;
        st[4] = key_q[255:128] ^ nonce_q;
        st[5] = '0;
        st[6] = key_q[127:0];
        st[7] = '0;
        for (int i = 0; i < 20; i++) advance(ZC0, ZC1);
        ad_total = 0;
        msg_total = 0;
      end
      CMD_AD: begin
        advance(blk[127:0], blk[255:128]);
        ad_total += 64'(n);
      end
      CMD_MSG: begin
        ks[127:0]   = aes_mix(st[1], st[5]);
        ks[255:128] = aes_mix(st[0] ^ st[4], st[2]);
        ct = (blk ^ ks) & mask;
        // The state absorbs the plaintext: the output in decrypt mode.
        fed = decrypt_q ? ct : blk;
        advance(fed[127:0], fed[255:128]);
        msg_total += 64'(n);
        b.data = ct;
        b.match = 1'b0;
        expected_beats.push_back(b);
      end
      default: begin
        for (int i = 0; i < 20; i++)
          advance({64'd0, ad_total << 3}, {64'd0, msg_total << 3});
        tag = st[0];
        for (int i = 1; i < 8; i++) tag ^= st[i];
        b.data = {128'd0, tag};
        b.match = decrypt_q && (tag == din[127:0]);
        expected_beats.push_back(b);
      end
    endcase
  endtask

  assign pending_o = expected_beats.size();

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t e;
    if (!rst_ni) begin
      key_q <= '0;
      nonce_q <= '0;
      decrypt_q <= 1'b0;
      for (int i = 0; i < 8; i++) st[i] = '0;
      ad_total = 0;
      msg_total = 0;
      fail_count <= 0;
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (reg_idx_e'(paddr[5:3]))
          REG_KEY0:   key_q[63:0]    <= pwdata;
          REG_KEY1:   key_q[127:64]  <= pwdata;
          REG_KEY2:   key_q[191:128] <= pwdata;
          REG_KEY3:   key_q[255:192] <= pwdata;
          REG_NONCE0: nonce_q[63:0]   <= pwdata;
          REG_NONCE1: nonce_q[127:64] <= pwdata;
          REG_MODE:   decrypt_q <= pwdata[0];
          default: ;
        endcase
      end
      // A result beat is checked before the input beat of the same edge is
      // predicted; a new result can never leave in its own accept cycle.
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %h match %b", $time, out_data, out_match);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_beats.pop_front();
          if (e.data !== out_data || e.match !== out_match) begin
            $display("%0t: result mismatch expected %h/%b actual %h/%b",
                     $time, e.data, e.match, out_data, out_match);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_beat(in_cmd, in_data, in_count);
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rocca_pkg::*;
  import rocca_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  int                 fail_count, pending;
  int                 cycle_count = 0;
  bit                 busy_phase = 1'b1;  // Throttling on or off for the sink.

  rocca_in_if  in_ch ();
  rocca_out_if out_ch ();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rocca_aead_core i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  rocca_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
    .in_data({in_ch.data_w3, in_ch.data_w2, in_ch.data_w1, in_ch.data_w0}),
    .in_count(in_ch.byte_count),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data({out_ch.out_w3, out_ch.out_w2, out_ch.out_w1, out_ch.out_w0}),
    .out_match(out_ch.tag_match),
    .fail_count(fail_count), .pending_o(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_INIT;
    in_ch.data_w0 = '0;
    in_ch.data_w1 = '0;
    in_ch.data_w2 = '0;
    in_ch.data_w3 = '0;
    in_ch.byte_count = '0;
    out_ch.ready = 1'b0;
  end

  // The sink stalls about a quarter of the time while busy_phase is set.
  always @(posedge clk_i) begin
    out_ch.ready <= busy_phase ? ($urandom_range(99) >= 25) : 1'b1;
  end

  // Watchdog. The slowest run has some 750 beats plus sink stalls;
  // this limit covers that many times over.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Setup phase, then access phase, then the bus goes idle.
  task automatic reg_write(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= reg_addr(idx);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Presents one beat and holds it until the core takes it. Random gaps
  // come first, so the beat stays up across consecutive items.
  task automatic send_beat(input cmd_e cmd, input logic [255:0] data,
                           input logic [5:0] cnt, input bit gaps);
    if (gaps && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    {in_ch.data_w3, in_ch.data_w2, in_ch.data_w1, in_ch.data_w0} <= data;
    in_ch.byte_count <= cnt;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // An AD block or init may still be in flight; let it finish.
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [255:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom};
  endfunction

  function automatic logic [5:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 6'd32;
    if (r < 45) return 6'd0;
    if (r < 50) return 6'($urandom_range(63, 33));
    return 6'($urandom_range(31, 1));
  endfunction

  task automatic load_config(input bit dec);
    reg_write(REG_KEY0, {$urandom, $urandom});
    reg_write(REG_KEY1, {$urandom, $urandom});
    reg_write(REG_KEY2, {$urandom, $urandom});
    reg_write(REG_KEY3, {$urandom, $urandom});
    reg_write(REG_NONCE0, {$urandom, $urandom});
    reg_write(REG_NONCE1, {$urandom, $urandom});
    reg_write(REG_MODE, DATA_W'(dec));
  endtask

  initial begin
    int           items;
    int           nad, nmsg;
    logic [255:0] blk;
    cmd_e         c;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Commands before init work on the all-zero state.
    send_beat(CMD_MSG, '1, 6'd32, 0);
    send_beat(CMD_AD, '0, 6'd0, 0);
    send_beat(CMD_FIN, '0, 6'd32, 0);
    drain();
    // All-ones key and nonce in decrypt mode.
    reg_write(REG_KEY0, '1);
    reg_write(REG_KEY1, '1);
    reg_write(REG_KEY2, '1);
    reg_write(REG_KEY3, '1);
    reg_write(REG_NONCE0, '1);
    reg_write(REG_NONCE1, '1);
    reg_write(REG_MODE, DATA_W'(1));
    send_beat(CMD_INIT, '0, 6'd0, 0);
    send_beat(CMD_AD, '1, 6'd1, 0);
    send_beat(CMD_AD, '1, 6'd63, 0);
    send_beat(CMD_MSG, '1, 6'd31, 0);
    send_beat(CMD_MSG, '0, 6'd1, 0);
    send_beat(CMD_MSG, rand_block(), 6'd0, 0);
    send_beat(CMD_MSG, rand_block(), 6'd40, 0);
    send_beat(CMD_FIN, '1, 6'd32, 0);
    send_beat(CMD_FIN, rand_block(), 6'd32, 0);
    drain();
    reg_write(REG_KEY0, '0);
    reg_write(REG_KEY1, '0);
    reg_write(REG_KEY2, '0);
    reg_write(REG_KEY3, '0);
    reg_write(REG_NONCE0, '0);
    reg_write(REG_NONCE1, '0);
    reg_write(REG_MODE, '0);
    send_beat(CMD_INIT, rand_block(), 6'd17, 0);
    send_beat(CMD_MSG, '1, 6'd32, 0);
    send_beat(CMD_FIN, '0, 6'd32, 0);
    drain();

    // Random part: mostly well-formed sessions, some stray commands.
    items = 0;
    while (items < 700) begin
      load_config($urandom_range(1));
      busy_phase = (items < 250 || items > 450);
      send_beat(CMD_INIT, rand_block(), rand_count(), busy_phase);
      nad = $urandom_range(4);
      nmsg = $urandom_range(8);
      for (int i = 0; i < nad; i++)
        send_beat(CMD_AD, rand_block(), rand_count(), busy_phase);
      for (int i = 0; i < nmsg; i++) begin
        if ($urandom_range(9) == 0) begin
          c = cmd_e'($urandom_range(3));
          send_beat(c, rand_block(), rand_count(), busy_phase);
        end else begin
          send_beat(CMD_MSG, rand_block(), rand_count(), busy_phase);
        end
        if (i == 2 && $urandom_range(3) == 0) begin
          // Hold the sender until every result is back.
          in_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
      blk = rand_block();
      send_beat(CMD_FIN, blk, rand_count(), busy_phase);
      items += 2 + nad + nmsg;
      drain();
    end

    busy_phase = 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
